FILE: hw/rtl/lpg_pkg.sv
package lpg_pkg;

	// Default coordinate width and queue depth.
	localparam int COORD_BITS_DEF  = 10;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Pixel colors.
	localparam int          COLOR_BITS  = 4;
	localparam logic [3:0]  COLOR_FIRST = 4'd5;
	localparam logic [3:0]  COLOR_NEXT  = 4'd10;

	// Request kinds carried on the input tuser bit.
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	// Width of one prepared request in the queue between front and back:
	// cmd, start x, start y, error term, two increments, two directions,
	// the major-axis flag and the major length.
	function automatic int lpg_item_bits(input int coord_bits);
		return 6 * coord_bits + 13;
	endfunction

	// Stream payload widths, rounded up to whole bytes.
	function automatic int lpg_bytes_bits(input int bits);
		return ((bits + 7) / 8) * 8;
	endfunction

endpackage

FILE: hw/rtl/lpg_front.sv
module lpg_front #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  lpg_pkg::cmd_t                             in_cmd,
	input  logic [COORD_BITS-1:0]                     in_start_x,
	input  logic [COORD_BITS-1:0]                     in_start_y,
	input  logic [COORD_BITS-1:0]                     in_end_x,
	input  logic [COORD_BITS-1:0]                     in_end_y,
	output logic                                      push_valid,
	input  logic                                      push_ready,
	output logic [lpg_pkg::lpg_item_bits(COORD_BITS)-1:0] push_data
);
	import lpg_pkg::*;

	localparam int C = COORD_BITS;

	// Stage 1: signed deltas folded into magnitude and direction.
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic [C-1:0]  sx_s1;
	logic [C-1:0]  sy_s1;
	logic [C-1:0]  absx_s1;
	logic [C-1:0]  absy_s1;
	logic [1:0]    dirx_s1;
	logic [1:0]    diry_s1;

	logic [C:0]    ddx;
	logic [C:0]    ddy;
	logic [C:0]    negx;
	logic [C:0]    negy;
	logic          load_s1;

	assign ddx     = {1'b0, in_end_x} - {1'b0, in_start_x};
	assign ddy     = {1'b0, in_end_y} - {1'b0, in_start_y};
	assign negx    = (C+1)'(0) - ddx;
	assign negy    = (C+1)'(0) - ddy;
	assign in_ready = !valid_s1 || push_ready;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1  <= in_cmd;
			sx_s1   <= in_start_x;
			sy_s1   <= in_start_y;
			absx_s1 <= ddx[C] ? negx[C-1:0] : ddx[C-1:0];
			absy_s1 <= ddy[C] ? negy[C-1:0] : ddy[C-1:0];
			dirx_s1 <= ddx[C] ? 2'b11 : ((ddx != '0) ? 2'b01 : 2'b00);
			diry_s1 <= ddy[C] ? 2'b11 : ((ddy != '0) ? 2'b01 : 2'b00);
		end
	end

	// Second half: pick the major axis and set up the error terms.
	logic          y_major;
	logic [C-1:0]  major;
	logic [C-1:0]  minor;
	logic [C+2:0]  err_init;
	logic [C+1:0]  inc_minor;
	logic [C:0]    diff;
	logic [C+1:0]  inc_diag;

	always_comb begin
		y_major   = absy_s1 > absx_s1;
		major     = y_major ? absy_s1 : absx_s1;
		minor     = y_major ? absx_s1 : absy_s1;
		err_init  = {2'b00, minor, 1'b0} - {3'b000, major};
		inc_minor = {1'b0, minor, 1'b0};
		diff      = {1'b0, minor} - {1'b0, major};
		inc_diag  = {diff, 1'b0};
	end

	assign push_valid = valid_s1;
	assign push_data  = {cmd_s1, sx_s1, sy_s1, err_init, inc_minor, inc_diag,
		dirx_s1, diry_s1, y_major, major};

endmodule

FILE: hw/rtl/lpg_queue.sv
module lpg_queue #(
	parameter int WIDTH = lpg_pkg::lpg_item_bits(lpg_pkg::COORD_BITS_DEF),
	parameter int DEPTH = lpg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import lpg_pkg::*;

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = count_q != FULL_CNT;
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/lpg_back.sv
module lpg_back #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      pop_valid,
	output logic                                      pop_ready,
	input  logic [lpg_pkg::lpg_item_bits(COORD_BITS)-1:0] pop_data,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [COORD_BITS-1:0]                     out_x,
	output logic [COORD_BITS-1:0]                     out_y,
	output logic [lpg_pkg::COLOR_BITS-1:0]            out_color,
	output logic                                      out_last
);
	import lpg_pkg::*;

	localparam int C = COORD_BITS;

	// Unpacked request.
	logic          r_cmd;
	logic [C-1:0]  r_sx;
	logic [C-1:0]  r_sy;
	logic [C+2:0]  r_err;
	logic [C+1:0]  r_inc_minor;
	logic [C+1:0]  r_inc_diag;
	logic [1:0]    r_dirx;
	logic [1:0]    r_diry;
	logic          r_y_major;
	logic [C-1:0]  r_major;

	assign {r_cmd, r_sx, r_sy, r_err, r_inc_minor, r_inc_diag,
		r_dirx, r_diry, r_y_major, r_major} = pop_data;

	// Line state.
	logic [C-1:0]  cur_x_q;
	logic [C-1:0]  cur_y_q;
	logic [C+2:0]  err_q;
	logic [C+1:0]  inc_minor_q;
	logic [C+1:0]  inc_diag_q;
	logic [1:0]    dir_x_q;
	logic [1:0]    dir_y_q;
	logic          y_major_q;
	logic [C-1:0]  steps_q;
	logic          active_q;

	// Output register.
	logic          out_valid_q;
	logic [C-1:0]  out_x_q;
	logic [C-1:0]  out_y_q;
	logic [COLOR_BITS-1:0] out_color_q;
	logic          out_last_q;

	logic          take;
	logic          is_start;
	logic          do_step;
	logic          err_neg;
	logic          move_x;
	logic          move_y;
	logic [C-1:0]  next_x;
	logic [C-1:0]  next_y;
	logic [C+2:0]  next_err;
	logic [C-1:0]  next_steps;

	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign is_start  = r_cmd == CMD_START;
	assign do_step   = take && !is_start && active_q;

	always_comb begin
		err_neg    = err_q[C+2];
		move_x     = !err_neg || !y_major_q;
		move_y     = !err_neg || y_major_q;
		next_x     = move_x ? cur_x_q + {{(C-2){dir_x_q[1]}}, dir_x_q} : cur_x_q;
		next_y     = move_y ? cur_y_q + {{(C-2){dir_y_q[1]}}, dir_y_q} : cur_y_q;
		next_err   = err_q + (err_neg ? {inc_minor_q[C+1], inc_minor_q}
			: {inc_diag_q[C+1], inc_diag_q});
		next_steps = steps_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			err_q       <= '0;
			inc_minor_q <= '0;
			inc_diag_q  <= '0;
			dir_x_q     <= '0;
			dir_y_q     <= '0;
			y_major_q   <= 1'b0;
			steps_q     <= '0;
		end else begin
			if (take) begin
				out_valid_q <= is_start || active_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && is_start) begin
				cur_x_q     <= r_sx;
				cur_y_q     <= r_sy;
				err_q       <= r_err;
				inc_minor_q <= r_inc_minor;
				inc_diag_q  <= r_inc_diag;
				dir_x_q     <= r_dirx;
				dir_y_q     <= r_diry;
				y_major_q   <= r_y_major;
				steps_q     <= r_major;
				active_q    <= r_major != '0;
			end else if (do_step) begin
				cur_x_q  <= next_x;
				cur_y_q  <= next_y;
				err_q    <= next_err;
				steps_q  <= next_steps;
				active_q <= next_steps != '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_start) begin
			out_x_q     <= r_sx;
			out_y_q     <= r_sy;
			out_color_q <= COLOR_FIRST;
			out_last_q  <= r_major == '0;
		end else if (do_step) begin
			out_x_q     <= next_x;
			out_y_q     <= next_y;
			out_color_q <= COLOR_NEXT;
			out_last_q  <= next_steps == '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_color = out_color_q;
	assign out_last  = out_last_q;

endmodule

FILE: hw/rtl/line_pixel_generator.sv
// Bresenham line rasterizer for all eight octants. A start request (tuser 0)
// latches both endpoints, derives the step direction on each axis, makes y the
// major axis when |dy| > |dx|, and returns the start pixel in color 5. Each step
// request (tuser 1) then returns the next pixel in color 10, moving along the
// major axis every time and along the minor axis when the error term is not
// negative; tlast marks the endpoint, so a line of major length L gives L+1
// pixels. A step request while no line is in progress is consumed without a
// result, and a start request drops any line still in progress. The block
// takes one request per clock cycle, sustained, and returns one pixel per
// cycle while the output side keeps tready high. A request passes one front
// register (delta, magnitude and direction), has its major axis chosen and its
// error terms set up on the way into a short queue, and then reaches the back
// stage, whose error update and coordinate increment is the loop that sets
// that rate; a request passes the front register and then a queue entry
// before its pixel reaches the output register. The queue lets the front
// keep taking requests for a while when the output side is stalled, and the
// back stage takes its next request in the same cycle that the waiting pixel
// is accepted.
module line_pixel_generator #(
	parameter int COORD_BITS  = lpg_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// Request stream.
	input  logic s_tvalid,
	output logic s_tready,
	// From bit 0 up: start_x, start_y, end_x, end_y.
	input  logic [lpg_pkg::lpg_bytes_bits(4*COORD_BITS)-1:0] s_tdata,
	// Bit 0: cmd (0 start a line, 1 step to the next pixel).
	input  logic [0:0] s_tuser,
	// Pixel stream.
	output logic m_tvalid,
	input  logic m_tready,
	// From bit 0 up: pixel_x, pixel_y, pixel_color, then zero padding.
	output logic [lpg_pkg::lpg_bytes_bits(2*COORD_BITS+lpg_pkg::COLOR_BITS)-1:0] m_tdata,
	output logic m_tlast
);
	import lpg_pkg::*;

	localparam int C        = COORD_BITS;
	localparam int ITEM_W   = lpg_item_bits(COORD_BITS);
	localparam int M_DATA_W = lpg_bytes_bits(2*COORD_BITS + COLOR_BITS);

	logic              push_valid;
	logic              push_ready;
	logic [ITEM_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [ITEM_W-1:0] pop_data;

	logic [C-1:0]          pix_x;
	logic [C-1:0]          pix_y;
	logic [COLOR_BITS-1:0] pix_color;

	lpg_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser[0])),
		.in_start_x(s_tdata[C-1:0]),
		.in_start_y(s_tdata[2*C-1:C]),
		.in_end_x  (s_tdata[3*C-1:2*C]),
		.in_end_y  (s_tdata[4*C-1:3*C]),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	lpg_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	lpg_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_x    (pix_x),
		.out_y    (pix_y),
		.out_color(pix_color),
		.out_last (m_tlast)
	);

	assign m_tdata = M_DATA_W'({pix_color, pix_y, pix_x});

endmodule

FILE: hw/rtl/lpg_checker.sv
module lpg_checker #(
	parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [lpg_pkg::lpg_bytes_bits(2*COORD_BITS+lpg_pkg::COLOR_BITS)-1:0] m_tdata,
	input logic m_tlast
);
	import lpg_pkg::*;

	localparam int C = COORD_BITS;

	logic                  m_take;
	logic [C-1:0]          px;
	logic [C-1:0]          py;
	logic [COLOR_BITS-1:0] pc;
	logic [C-1:0]          prev_x_q;
	logic [C-1:0]          prev_y_q;
	logic [C-1:0]          dx;
	logic [C-1:0]          dy;

	assign m_take = m_tvalid && m_tready;
	assign px     = m_tdata[C-1:0];
	assign py     = m_tdata[2*C-1:C];
	assign pc     = m_tdata[2*C+COLOR_BITS-1:2*C];
	assign dx     = px - prev_x_q;
	assign dy     = py - prev_y_q;

	// The last accepted pixel, for the neighbor check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (m_take) begin
			prev_x_q <= px;
			prev_y_q <= py;
		end
	end

	// A stalled pixel is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("pixel changed while stalled");

	// Only the two line colors are ever produced.
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pc == COLOR_FIRST || pc == COLOR_NEXT))
		else $error("unexpected pixel color");

	// After an endpoint the next pixel must open a new line.
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_take && m_tlast ##1 m_take |-> pc == COLOR_FIRST)
		else $error("step pixel after line endpoint");

	// Consecutive pixels of one line are neighbors that differ in at least one axis.
	a_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		m_take && !m_tlast ##1 m_take && pc == COLOR_NEXT |->
		(dx == '0 || dx == C'(1) || dx == '1) &&
		(dy == '0 || dy == C'(1) || dy == '1) &&
		(dx != '0 || dy != '0))
		else $error("step pixel not adjacent to previous pixel");

	// No pixel is offered while reset is held.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("pixel offered during reset");

endmodule

bind line_pixel_generator lpg_checker #(
	.COORD_BITS(COORD_BITS)
) u_lpg_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
